### rtl/rkf_pkg.sv
package rkf_pkg;

   // Input item modes.
   typedef enum logic [2:0] {
      MODE_WR_X    = 3'd0,
      MODE_WR_P    = 3'd1,
      MODE_MEASURE = 3'd2,
      MODE_TIMEOUT = 3'd3,
      MODE_RD_X    = 3'd4,
      MODE_RD_P    = 3'd5
   } mode_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_CORRECTED  = 3'd0,
      ST_RANGE      = 3'd1,
      ST_FAULT      = 3'd2,
      ST_TIMEOUT    = 3'd3,
      ST_NO_TIMEOUT = 3'd4,
      ST_DONE       = 3'd5
   } status_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MIN_RANGE   = 3'd0;
   localparam logic [2:0] CSR_MAX_RANGE   = 3'd1;
   localparam logic [2:0] CSR_MOUNT_OFS   = 3'd2;
   localparam logic [2:0] CSR_DEF_VAR     = 3'd3;
   localparam logic [2:0] CSR_FAULT_LIM   = 3'd4;
   localparam logic [2:0] CSR_TIMEOUT_LIM = 3'd5;

   // Fixed-point constants (Q16.16).
   localparam logic [31:0] EPS_Q     = 32'd3277;
   localparam logic [30:0] VAR_MIN_Q = 31'd66;
   localparam logic [31:0] I32_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] I32_MIN   = 32'h8000_0000;
   localparam logic [30:0] BETA_MAX  = 31'h7FFF_FFFF;

   // Controller states.
   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_READ_DONE, S_TILT1, S_TILT2, S_TILT3,
      S_PC_RD, S_PC_ACC, S_XR_RD, S_XR_ACC, S_S_ACC, S_FIN, S_RR_MUL,
      S_BETA_START, S_BETA_WAIT, S_BETA_END, S_GAIN_START, S_GAIN_WAIT,
      S_GAIN_END, S_XU_RD, S_XU_WR, S_PU_RD, S_PU_WR, S_OUT
   } ctrl_state_type;

   // Datapath operations.
   typedef enum logic [4:0] {
      OP_NONE, OP_CAPTURE, OP_DISPATCH, OP_READ_DONE, OP_TILT1, OP_TILT2,
      OP_TILT3, OP_PC_RD, OP_PC_ACC, OP_XR_RD, OP_XR_ACC, OP_S_ACC, OP_FIN,
      OP_RR_MUL, OP_BETA_START, OP_BETA_END, OP_GAIN_START, OP_GAIN_END,
      OP_XU_RD, OP_XU_WR, OP_PU_RD, OP_PU_WR, OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type   op;
      logic [1:0]  sub;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     gate_ok;
      logic     s_pos;
      logic     beta_fault;
      logic     div_done;
      logic     out_free;
   } dp_sts_type;

   // Saturate a wide signed value to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [71:0] v);
      if (v[71:31] == '0 || v[71:31] == '1) begin
         return v[31:0];
      end
      return v[71] ? I32_MIN : I32_MAX;
   endfunction

endpackage

### rtl/rkf_ram.sv
module rkf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rkf_div.sv
module rkf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [30:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   localparam int DW = 64;
   localparam int CW = $clog2(DW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [30:0]   rem_ff, rem_in;
   logic [63:0]   quo_ff, quo_in;
   logic [30:0]   dvs_ff, dvs_in;
   logic [31:0]   rem_sh;
   logic [32:0]   diff;

   // Restoring division, one quotient bit per cycle; the dividend shifts
   // out of the top of quo_ff while quotient bits shift in at the bottom.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[63]};
      diff    = {1'b0, rem_sh} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[30:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[30:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/rkf_dp.sv
module rkf_dp #(
   parameter int NUM_STATES    = 10,
   parameter int Z_INDEX       = 2,
   parameter int TERRAIN_INDEX = 9
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rkf_pkg::dp_cmd_type            cmd,
   input  logic [$clog2(NUM_STATES)-1:0]  idx_i,
   input  logic [$clog2(NUM_STATES)-1:0]  idx_j,
   output rkf_pkg::dp_sts_type            sts,
   input  logic [2:0]                     req_mode,
   input  logic [3:0]                     req_row_index,
   input  logic [3:0]                     req_col_index,
   input  logic signed [31:0]             req_load_value,
   input  logic [30:0]                    req_range_sample,
   input  logic [30:0]                    req_sample_variance,
   input  logic signed [17:0]             req_cos_roll,
   input  logic signed [17:0]             req_cos_pitch,
   input  logic [63:0]                    req_time_us,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic signed [31:0]             rsp_read_data,
   output logic signed [31:0]             rsp_residual,
   output logic [30:0]                    rsp_beta,
   output logic                           rsp_fault_flag,
   output logic                           rsp_timeout_flag,
   output logic                           rsp_recovered_flag,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [2:0]                     csr_index,
   input  logic [31:0]                    csr_data
);

   localparam int IW = $clog2(NUM_STATES);
   localparam int PD = NUM_STATES * NUM_STATES;
   localparam int PW = $clog2(PD);
   localparam bit CZ = (Z_INDEX < NUM_STATES) && (Z_INDEX != TERRAIN_INDEX);
   localparam bit CT = (TERRAIN_INDEX < NUM_STATES);
   localparam logic [IW-1:0] ZI = CZ ? IW'(Z_INDEX) : '0;
   localparam logic [IW-1:0] TI = CT ? IW'(TERRAIN_INDEX) : '0;

   function automatic logic [PW-1:0] p_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
      int a;
      a = int'(r) * NUM_STATES + int'(c);
      return PW'(a);
   endfunction

   // Configuration registers.
   logic [30:0] min_range_ff, max_range_ff, def_var_ff;
   logic [31:0] mount_ofs_ff, timeout_lim_ff;
   logic [15:0] fault_lim_ff;

   // Control state.
   logic [63:0] last_time_ff;
   logic        fault_ff, timeout_ff, recov_ff, rsp_valid_ff;

   // Captured item.
   rkf_pkg::mode_type  mode_ff;
   logic [3:0]         row_ff, col_ff;
   logic [31:0]        load_ff;
   logic [30:0]        rng_ff, var_ff;
   logic signed [17:0] cr_ff, cp_ff;
   logic [63:0]        time_ff;

   // Working registers.
   logic signed [66:0] prod_ff;
   logic [31:0]        y_ff, s_ff, r_ff, k_ff, read_ff;
   logic [30:0]        rv_ff, beta_ff;
   logic signed [33:0] acc_pc_ff, acc_cpv_ff, acc_x_ff, acc_s_ff;
   logic [31:0]        pc_ff [NUM_STATES];
   logic [31:0]        cpv_ff [NUM_STATES];
   logic               gneg_ff;
   rkf_pkg::status_type status_ff;

   // Result register.
   logic [2:0]  out_status_ff;
   logic [31:0] out_read_ff, out_res_ff;
   logic [30:0] out_beta_ff;
   logic        out_fault_ff, out_timeout_ff, out_recov_ff;

   // Combinational.
   logic               rok, cok, gate_ok, beta_fault, div_done;
   logic signed [32:0] gate_lo, gate_hi, rng_s;
   logic [63:0]        dt;
   logic signed [34:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [66:0] prod_c;
   logic [31:0]        x_rdata, p_rdata;
   logic signed [33:0] p_data34, x_data34;
   logic signed [33:0] acc_pc_nx, acc_cpv_nx;
   logic [IW-1:0]      x_rd_addr, x_wr_addr, pc_idx;
   logic [PW-1:0]      p_rd_addr, p_wr_addr;
   logic               x_we, p_we;
   logic [31:0]        x_wdata, p_wdata, pc_sel, pc_cur;
   logic [63:0]        div_q, div_dividend;
   logic               div_start;
   logic [30:0]        beta_sat;
   logic signed [32:0] pc33, mag33;
   logic [31:0]        k_next, upd_term;

   assign rok = int'(row_ff) < NUM_STATES;
   assign cok = int'(col_ff) < NUM_STATES;

   // Range gate: max-eps >= d >= min+eps (min+eps is never below eps).
   assign rng_s   = $signed({2'b00, rng_ff});
   assign gate_lo = $signed({2'b00, min_range_ff}) + $signed({1'b0, rkf_pkg::EPS_Q});
   assign gate_hi = $signed({2'b00, max_range_ff}) - $signed({1'b0, rkf_pkg::EPS_Q});
   assign gate_ok = (rng_s >= gate_lo) && (rng_s <= gate_hi);

   assign dt = (time_ff > last_time_ff) ? (time_ff - last_time_ff) : (last_time_ff - time_ff);

   // Shared multiplier; every product lands in prod_ff.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         rkf_pkg::OP_TILT1: begin
            mul_a = $signed({4'b0000, rng_ff}) + 35'($signed(mount_ofs_ff));
            mul_b = 32'(cr_ff);
         end
         rkf_pkg::OP_TILT2: begin
            mul_a = 35'(prod_ff >>> 16);
            mul_b = 32'(cp_ff);
         end
         rkf_pkg::OP_RR_MUL: begin
            mul_a = 35'($signed(r_ff));
            mul_b = $signed(r_ff);
         end
         rkf_pkg::OP_XU_RD: begin
            mul_a = 35'($signed(k_ff));
            mul_b = $signed(r_ff);
         end
         rkf_pkg::OP_PU_RD: begin
            mul_a = 35'($signed(k_ff));
            mul_b = $signed(cpv_ff[idx_j]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_c = mul_a * mul_b;

   // Covariance column/row accumulation for P*C' and C*P.
   assign p_data34 = 34'($signed(p_rdata));
   assign x_data34 = 34'($signed(x_rdata));

   always_comb begin
      acc_pc_nx  = acc_pc_ff;
      acc_cpv_nx = acc_cpv_ff;
      case (cmd.sub)
         2'd0:    acc_pc_nx  = acc_pc_ff - (CZ ? p_data34 : '0);
         2'd1:    acc_pc_nx  = acc_pc_ff + (CT ? p_data34 : '0);
         2'd2:    acc_cpv_nx = acc_cpv_ff - (CZ ? p_data34 : '0);
         default: acc_cpv_nx = acc_cpv_ff + (CT ? p_data34 : '0);
      endcase
   end

   assign pc_idx = (cmd.op == rkf_pkg::OP_S_ACC) ? ((cmd.sub == 2'd0) ? ZI : TI) : idx_i;
   assign pc_sel = pc_ff[pc_idx];
   assign pc_cur = pc_sel;

   // Memory addressing.
   always_comb begin
      x_rd_addr = '0;
      p_rd_addr = '0;
      x_we      = 1'b0;
      p_we      = 1'b0;
      x_wr_addr = row_ff[IW-1:0];
      p_wr_addr = p_addr(row_ff[IW-1:0], col_ff[IW-1:0]);
      x_wdata   = load_ff;
      p_wdata   = load_ff;
      upd_term  = rkf_pkg::sat32(72'(prod_ff >>> 16));
      case (cmd.op)
         rkf_pkg::OP_DISPATCH: begin
            x_rd_addr = row_ff[IW-1:0];
            p_rd_addr = p_addr(row_ff[IW-1:0], col_ff[IW-1:0]);
            x_we      = (mode_ff == rkf_pkg::MODE_WR_X) && rok;
            p_we      = (mode_ff == rkf_pkg::MODE_WR_P) && rok && cok;
         end
         rkf_pkg::OP_PC_RD: begin
            case (cmd.sub)
               2'd0:    p_rd_addr = p_addr(idx_i, ZI);
               2'd1:    p_rd_addr = p_addr(idx_i, TI);
               2'd2:    p_rd_addr = p_addr(ZI, idx_i);
               default: p_rd_addr = p_addr(TI, idx_i);
            endcase
         end
         rkf_pkg::OP_XR_RD: begin
            x_rd_addr = (cmd.sub == 2'd0) ? ZI : TI;
         end
         rkf_pkg::OP_XU_RD: begin
            x_rd_addr = idx_i;
         end
         rkf_pkg::OP_XU_WR: begin
            x_we      = 1'b1;
            x_wr_addr = idx_i;
            x_wdata   = rkf_pkg::sat32(72'($signed(x_rdata)) + 72'($signed(upd_term)));
         end
         rkf_pkg::OP_PU_RD: begin
            p_rd_addr = p_addr(idx_i, idx_j);
         end
         rkf_pkg::OP_PU_WR: begin
            p_we      = 1'b1;
            p_wr_addr = p_addr(idx_i, idx_j);
            p_wdata   = rkf_pkg::sat32(72'($signed(p_rdata)) - 72'($signed(upd_term)));
         end
         default: begin
            x_we = 1'b0;
         end
      endcase
   end

   rkf_ram #(.WIDTH(32), .DEPTH(NUM_STATES)) u_x_ram (
      .clock   (clock),
      .wr_en   (x_we),
      .wr_addr (x_wr_addr),
      .wr_data (x_wdata),
      .rd_addr (x_rd_addr),
      .rd_data (x_rdata)
   );

   rkf_ram #(.WIDTH(32), .DEPTH(PD)) u_p_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_wr_addr),
      .wr_data (p_wdata),
      .rd_addr (p_rd_addr),
      .rd_data (p_rdata)
   );

   // Divider operands: r*r / S for beta, |pc|*65536 / S for each gain.
   assign pc33  = $signed({pc_cur[31], pc_cur});
   assign mag33 = pc33[32] ? -pc33 : pc33;
   assign div_start    = (cmd.op == rkf_pkg::OP_BETA_START) || (cmd.op == rkf_pkg::OP_GAIN_START);
   assign div_dividend = (cmd.op == rkf_pkg::OP_GAIN_START) ?
                         {15'd0, mag33, 16'd0} : prod_ff[63:0];

   rkf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (s_ff[30:0]),
      .done     (div_done),
      .quotient (div_q)
   );

   assign beta_sat   = (|div_q[63:31]) ? rkf_pkg::BETA_MAX : div_q[30:0];
   assign beta_fault = {1'b0, beta_sat} > {fault_lim_ff, 16'd0};

   // Gain is rounded toward zero, then saturated.
   always_comb begin
      if (!gneg_ff) begin
         k_next = (|div_q[63:31]) ? rkf_pkg::I32_MAX : {1'b0, div_q[30:0]};
      end else if ((|div_q[63:32]) || (div_q[31] && (|div_q[30:0]))) begin
         k_next = rkf_pkg::I32_MIN;
      end else begin
         k_next = 32'd0 - div_q[31:0];
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff   <= '0;
         max_range_ff   <= 31'd2621440;
         mount_ofs_ff   <= '0;
         def_var_ff     <= 31'd655;
         fault_lim_ff   <= 16'd700;
         timeout_lim_ff <= 32'd100000;
         last_time_ff   <= '0;
         fault_ff       <= 1'b0;
         timeout_ff     <= 1'b0;
         recov_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               rkf_pkg::CSR_MIN_RANGE:   min_range_ff   <= csr_data[30:0];
               rkf_pkg::CSR_MAX_RANGE:   max_range_ff   <= csr_data[30:0];
               rkf_pkg::CSR_MOUNT_OFS:   mount_ofs_ff   <= csr_data;
               rkf_pkg::CSR_DEF_VAR:     def_var_ff     <= csr_data[30:0];
               rkf_pkg::CSR_FAULT_LIM:   fault_lim_ff   <= csr_data[15:0];
               rkf_pkg::CSR_TIMEOUT_LIM: timeout_lim_ff <= csr_data;
               default: begin
               end
            endcase
         end
         case (cmd.op)
            rkf_pkg::OP_DISPATCH: begin
               if (mode_ff == rkf_pkg::MODE_TIMEOUT && dt > {32'd0, timeout_lim_ff}) begin
                  timeout_ff <= 1'b1;
               end
               if (mode_ff == rkf_pkg::MODE_MEASURE && gate_ok) begin
                  last_time_ff <= time_ff;
               end
            end
            rkf_pkg::OP_RR_MUL: begin
               if (s_ff[31] || s_ff == '0) begin
                  fault_ff <= 1'b1;
               end
            end
            rkf_pkg::OP_BETA_END: begin
               if (beta_fault) begin
                  fault_ff <= 1'b1;
               end else if (fault_ff) begin
                  fault_ff <= 1'b0;
                  recov_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (cmd.op == rkf_pkg::OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         rkf_pkg::OP_CAPTURE: begin
            mode_ff    <= rkf_pkg::mode_type'(req_mode);
            row_ff     <= req_row_index;
            col_ff     <= req_col_index;
            load_ff    <= req_load_value;
            rng_ff     <= req_range_sample;
            var_ff     <= req_sample_variance;
            cr_ff      <= req_cos_roll;
            cp_ff      <= req_cos_pitch;
            time_ff    <= req_time_us;
            status_ff  <= rkf_pkg::ST_DONE;
            read_ff    <= '0;
            r_ff       <= '0;
            beta_ff    <= '0;
            acc_pc_ff  <= '0;
            acc_cpv_ff <= '0;
            acc_x_ff   <= '0;
            acc_s_ff   <= '0;
         end
         rkf_pkg::OP_DISPATCH: begin
            case (mode_ff)
               rkf_pkg::MODE_TIMEOUT: begin
                  status_ff <= (dt > {32'd0, timeout_lim_ff}) ?
                               rkf_pkg::ST_TIMEOUT : rkf_pkg::ST_NO_TIMEOUT;
               end
               rkf_pkg::MODE_MEASURE: begin
                  if (!gate_ok) begin
                     status_ff <= rkf_pkg::ST_RANGE;
                  end
                  rv_ff <= (var_ff < rkf_pkg::VAR_MIN_Q) ? def_var_ff : var_ff;
               end
               default: begin
               end
            endcase
         end
         rkf_pkg::OP_READ_DONE: begin
            if (mode_ff == rkf_pkg::MODE_RD_X) begin
               read_ff <= rok ? x_rdata : '0;
            end else begin
               read_ff <= (rok && cok) ? p_rdata : '0;
            end
         end
         rkf_pkg::OP_TILT1, rkf_pkg::OP_TILT2, rkf_pkg::OP_RR_MUL,
         rkf_pkg::OP_XU_RD, rkf_pkg::OP_PU_RD: begin
            prod_ff <= prod_c;
            if (cmd.op == rkf_pkg::OP_RR_MUL && (s_ff[31] || s_ff == '0)) begin
               beta_ff   <= rkf_pkg::BETA_MAX;
               status_ff <= rkf_pkg::ST_FAULT;
            end
         end
         rkf_pkg::OP_TILT3: begin
            y_ff <= rkf_pkg::sat32(72'(prod_ff >>> 16));
         end
         rkf_pkg::OP_PC_ACC: begin
            if (cmd.sub == 2'd3) begin
               pc_ff[idx_i]  <= rkf_pkg::sat32(72'(acc_pc_nx));
               cpv_ff[idx_i] <= rkf_pkg::sat32(72'(acc_cpv_nx));
               acc_pc_ff     <= '0;
               acc_cpv_ff    <= '0;
            end else begin
               acc_pc_ff  <= acc_pc_nx;
               acc_cpv_ff <= acc_cpv_nx;
            end
         end
         rkf_pkg::OP_XR_ACC: begin
            if (cmd.sub == 2'd0) begin
               acc_x_ff <= acc_x_ff - (CZ ? x_data34 : '0);
            end else begin
               acc_x_ff <= acc_x_ff + (CT ? x_data34 : '0);
            end
         end
         rkf_pkg::OP_S_ACC: begin
            if (cmd.sub == 2'd0) begin
               acc_s_ff <= acc_s_ff - (CZ ? 34'($signed(pc_sel)) : '0);
            end else begin
               acc_s_ff <= acc_s_ff + (CT ? 34'($signed(pc_sel)) : '0);
            end
         end
         rkf_pkg::OP_FIN: begin
            s_ff <= rkf_pkg::sat32(72'($signed(rkf_pkg::sat32(72'(acc_s_ff))))
                                   + 72'($signed({1'b0, rv_ff})));
            r_ff <= rkf_pkg::sat32(72'($signed(y_ff))
                                   - 72'($signed(rkf_pkg::sat32(72'(acc_x_ff)))));
         end
         rkf_pkg::OP_BETA_END: begin
            beta_ff   <= beta_sat;
            status_ff <= beta_fault ? rkf_pkg::ST_FAULT : rkf_pkg::ST_CORRECTED;
         end
         rkf_pkg::OP_GAIN_START: begin
            gneg_ff <= pc_cur[31];
         end
         rkf_pkg::OP_GAIN_END: begin
            k_ff <= k_next;
         end
         rkf_pkg::OP_OUT: begin
            out_status_ff  <= status_ff;
            out_read_ff    <= read_ff;
            out_res_ff     <= r_ff;
            out_beta_ff    <= beta_ff;
            out_fault_ff   <= fault_ff;
            out_timeout_ff <= timeout_ff;
            out_recov_ff   <= recov_ff;
         end
         default: begin
         end
      endcase
   end

   assign sts.mode       = mode_ff;
   assign sts.gate_ok    = gate_ok;
   assign sts.s_pos      = !s_ff[31] && (s_ff != '0);
   assign sts.beta_fault = beta_fault;
   assign sts.div_done   = div_done;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_read_data      = out_read_ff;
   assign rsp_residual       = out_res_ff;
   assign rsp_beta           = out_beta_ff;
   assign rsp_fault_flag     = out_fault_ff;
   assign rsp_timeout_flag   = out_timeout_ff;
   assign rsp_recovered_flag = out_recov_ff;

endmodule

### rtl/rkf_ctrl.sv
module rkf_ctrl #(
   parameter int NUM_STATES = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output rkf_pkg::dp_cmd_type           cmd,
   output logic [$clog2(NUM_STATES)-1:0] idx_i,
   output logic [$clog2(NUM_STATES)-1:0] idx_j,
   input  rkf_pkg::dp_sts_type           sts
);

   localparam int IW = $clog2(NUM_STATES);
   localparam logic [IW-1:0] LAST = IW'(NUM_STATES - 1);

   rkf_pkg::ctrl_state_type state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [1:0]    sub_ff, sub_in;

   // Next state and loop counters.
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      sub_in   = sub_ff;
      case (state_ff)
         rkf_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = rkf_pkg::S_DISPATCH;
            end
         end
         rkf_pkg::S_DISPATCH: begin
            i_in   = '0;
            j_in   = '0;
            sub_in = '0;
            case (sts.mode)
               rkf_pkg::MODE_RD_X, rkf_pkg::MODE_RD_P: state_in = rkf_pkg::S_READ_DONE;
               rkf_pkg::MODE_MEASURE: begin
                  state_in = sts.gate_ok ? rkf_pkg::S_TILT1 : rkf_pkg::S_OUT;
               end
               default: state_in = rkf_pkg::S_OUT;
            endcase
         end
         rkf_pkg::S_READ_DONE: state_in = rkf_pkg::S_OUT;
         rkf_pkg::S_TILT1:     state_in = rkf_pkg::S_TILT2;
         rkf_pkg::S_TILT2:     state_in = rkf_pkg::S_TILT3;
         rkf_pkg::S_TILT3:     state_in = rkf_pkg::S_PC_RD;
         rkf_pkg::S_PC_RD:     state_in = rkf_pkg::S_PC_ACC;
         rkf_pkg::S_PC_ACC: begin
            if (sub_ff == 2'd3) begin
               sub_in = '0;
               if (i_ff == LAST) begin
                  i_in     = '0;
                  state_in = rkf_pkg::S_XR_RD;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = rkf_pkg::S_PC_RD;
               end
            end else begin
               sub_in   = sub_ff + 2'd1;
               state_in = rkf_pkg::S_PC_RD;
            end
         end
         rkf_pkg::S_XR_RD: state_in = rkf_pkg::S_XR_ACC;
         rkf_pkg::S_XR_ACC: begin
            if (sub_ff == 2'd1) begin
               sub_in   = '0;
               state_in = rkf_pkg::S_S_ACC;
            end else begin
               sub_in   = 2'd1;
               state_in = rkf_pkg::S_XR_RD;
            end
         end
         rkf_pkg::S_S_ACC: begin
            if (sub_ff == 2'd1) begin
               sub_in   = '0;
               state_in = rkf_pkg::S_FIN;
            end else begin
               sub_in = 2'd1;
            end
         end
         rkf_pkg::S_FIN: state_in = rkf_pkg::S_RR_MUL;
         rkf_pkg::S_RR_MUL: begin
            state_in = sts.s_pos ? rkf_pkg::S_BETA_START : rkf_pkg::S_OUT;
         end
         rkf_pkg::S_BETA_START: state_in = rkf_pkg::S_BETA_WAIT;
         rkf_pkg::S_BETA_WAIT: begin
            if (sts.div_done) begin
               state_in = rkf_pkg::S_BETA_END;
            end
         end
         rkf_pkg::S_BETA_END: begin
            i_in     = '0;
            state_in = sts.beta_fault ? rkf_pkg::S_OUT : rkf_pkg::S_GAIN_START;
         end
         rkf_pkg::S_GAIN_START: state_in = rkf_pkg::S_GAIN_WAIT;
         rkf_pkg::S_GAIN_WAIT: begin
            if (sts.div_done) begin
               state_in = rkf_pkg::S_GAIN_END;
            end
         end
         rkf_pkg::S_GAIN_END: state_in = rkf_pkg::S_XU_RD;
         rkf_pkg::S_XU_RD:    state_in = rkf_pkg::S_XU_WR;
         rkf_pkg::S_XU_WR: begin
            j_in     = '0;
            state_in = rkf_pkg::S_PU_RD;
         end
         rkf_pkg::S_PU_RD: state_in = rkf_pkg::S_PU_WR;
         rkf_pkg::S_PU_WR: begin
            if (j_ff == LAST) begin
               j_in = '0;
               if (i_ff == LAST) begin
                  i_in     = '0;
                  state_in = rkf_pkg::S_OUT;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = rkf_pkg::S_GAIN_START;
               end
            end else begin
               j_in     = j_ff + IW'(1);
               state_in = rkf_pkg::S_PU_RD;
            end
         end
         rkf_pkg::S_OUT: begin
            if (sts.out_free) begin
               state_in = rkf_pkg::S_IDLE;
            end
         end
         default: state_in = rkf_pkg::S_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd.sub   = sub_ff;
      req_ready = 1'b0;
      case (state_ff)
         rkf_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = req_valid ? rkf_pkg::OP_CAPTURE : rkf_pkg::OP_NONE;
         end
         rkf_pkg::S_DISPATCH:   cmd.op = rkf_pkg::OP_DISPATCH;
         rkf_pkg::S_READ_DONE:  cmd.op = rkf_pkg::OP_READ_DONE;
         rkf_pkg::S_TILT1:      cmd.op = rkf_pkg::OP_TILT1;
         rkf_pkg::S_TILT2:      cmd.op = rkf_pkg::OP_TILT2;
         rkf_pkg::S_TILT3:      cmd.op = rkf_pkg::OP_TILT3;
         rkf_pkg::S_PC_RD:      cmd.op = rkf_pkg::OP_PC_RD;
         rkf_pkg::S_PC_ACC:     cmd.op = rkf_pkg::OP_PC_ACC;
         rkf_pkg::S_XR_RD:      cmd.op = rkf_pkg::OP_XR_RD;
         rkf_pkg::S_XR_ACC:     cmd.op = rkf_pkg::OP_XR_ACC;
         rkf_pkg::S_S_ACC:      cmd.op = rkf_pkg::OP_S_ACC;
         rkf_pkg::S_FIN:        cmd.op = rkf_pkg::OP_FIN;
         rkf_pkg::S_RR_MUL:     cmd.op = rkf_pkg::OP_RR_MUL;
         rkf_pkg::S_BETA_START: cmd.op = rkf_pkg::OP_BETA_START;
         rkf_pkg::S_BETA_END:   cmd.op = rkf_pkg::OP_BETA_END;
         rkf_pkg::S_GAIN_START: cmd.op = rkf_pkg::OP_GAIN_START;
         rkf_pkg::S_GAIN_END:   cmd.op = rkf_pkg::OP_GAIN_END;
         rkf_pkg::S_XU_RD:      cmd.op = rkf_pkg::OP_XU_RD;
         rkf_pkg::S_XU_WR:      cmd.op = rkf_pkg::OP_XU_WR;
         rkf_pkg::S_PU_RD:      cmd.op = rkf_pkg::OP_PU_RD;
         rkf_pkg::S_PU_WR:      cmd.op = rkf_pkg::OP_PU_WR;
         rkf_pkg::S_OUT: begin
            cmd.op = sts.out_free ? rkf_pkg::OP_OUT : rkf_pkg::OP_NONE;
         end
         default: cmd.op = rkf_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rkf_pkg::S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         sub_ff   <= sub_in;
      end
   end

   assign idx_i = i_ff;
   assign idx_j = j_ff;

endmodule

### rtl/range_kalman_update.sv
// Load, timeout check, unused modes and gated-out measurements go from dispatch straight
// to the result word; reads add a read step; an accepted measurement runs the full update.
// One word at a time: the next word is accepted once the result is in the output register;
// an accepted measurement is paced by the bit-serial divider and the covariance RAM port.
// Reset is synchronous, active high: flags, sample time, configuration registers and
// controller state take their reset values; state vector and covariance RAMs are not cleared.
module range_kalman_update #(
   parameter int NUM_STATES    = 10,
   parameter int Z_INDEX       = 2,
   parameter int TERRAIN_INDEX = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [3:0]         req_row_index,
   input  logic [3:0]         req_col_index,
   input  logic signed [31:0] req_load_value,
   input  logic [30:0]        req_range_sample,
   input  logic [30:0]        req_sample_variance,
   input  logic signed [17:0] req_cos_roll,
   input  logic signed [17:0] req_cos_pitch,
   input  logic [63:0]        req_time_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_read_data,
   output logic signed [31:0] rsp_residual,
   output logic [30:0]        rsp_beta,
   output logic               rsp_fault_flag,
   output logic               rsp_timeout_flag,
   output logic               rsp_recovered_flag,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int IW = $clog2(NUM_STATES);

   // The controller walks the measurement update as a fixed sequence: tilt correction,
   // the P*C' and C*P gather over the covariance RAM, innovation and its variance,
   // beta through the divider if the variance is positive, then, unless beta faults,
   // one gain per row, then that row's state and covariance writes. The datapath owns both RAMs,
   // the shared multiplier and the divider, and holds the finished result word until it is taken.
   rkf_pkg::dp_cmd_type cmd;
   rkf_pkg::dp_sts_type sts;
   logic [IW-1:0]       idx_i, idx_j;

   rkf_ctrl #(.NUM_STATES(NUM_STATES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .idx_i     (idx_i),
      .idx_j     (idx_j),
      .sts       (sts)
   );

   rkf_dp #(
      .NUM_STATES    (NUM_STATES),
      .Z_INDEX       (Z_INDEX),
      .TERRAIN_INDEX (TERRAIN_INDEX)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .idx_i               (idx_i),
      .idx_j               (idx_j),
      .sts                 (sts),
      .req_mode            (req_mode),
      .req_row_index       (req_row_index),
      .req_col_index       (req_col_index),
      .req_load_value      (req_load_value),
      .req_range_sample    (req_range_sample),
      .req_sample_variance (req_sample_variance),
      .req_cos_roll        (req_cos_roll),
      .req_cos_pitch       (req_cos_pitch),
      .req_time_us         (req_time_us),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_read_data       (rsp_read_data),
      .rsp_residual        (rsp_residual),
      .rsp_beta            (rsp_beta),
      .rsp_fault_flag      (rsp_fault_flag),
      .rsp_timeout_flag    (rsp_timeout_flag),
      .rsp_recovered_flag  (rsp_recovered_flag),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // A corrected measurement always leaves the fault flag clear.
   a_corrected_clears_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rkf_pkg::ST_CORRECTED |-> !rsp_fault_flag)
      else $error("corrected result with fault flag set");

   // A rejected measurement always reports the fault flag.
   a_reject_sets_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rkf_pkg::ST_FAULT |-> rsp_fault_flag)
      else $error("fault result without fault flag");

   // A detected timeout is reflected in the sticky flag of the same word.
   a_timeout_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rkf_pkg::ST_TIMEOUT |-> rsp_timeout_flag)
      else $error("timeout result without timeout flag");

   // Only an update that got past the range gate carries a residual or beta.
   a_no_update_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rkf_pkg::ST_RANGE || rsp_status == rkf_pkg::ST_DONE ||
                    rsp_status == rkf_pkg::ST_TIMEOUT || rsp_status == rkf_pkg::ST_NO_TIMEOUT)
      |-> rsp_residual == 0 && rsp_beta == 0)
      else $error("residual or beta set without a measurement");

endmodule
